>>> hdl/dtd_pkg.sv
// Shared types, register codes and constant tables for the day-distance block.
// Used by every module under hdl; depends on nothing else.
package dtd_pkg;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int COUNT_W    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    // Adjusted year runs from -1 to 16384.
    localparam int ADJ_W      = 16;
    // Day numbers and their difference stay well inside 25 signed bits.
    localparam int DAYNUM_W   = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_YEAR   = 3'd0,
        CFG_FIRST_MONTH  = 3'd1,
        CFG_FIRST_DAY    = 3'd2,
        CFG_SECOND_YEAR  = 3'd3,
        CFG_SECOND_MONTH = 3'd4,
        CFG_SECOND_DAY   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    localparam t_date RST_FIRST  = '{year: 14'd0,    month: 4'd1, day: 5'd1};
    localparam t_date RST_SECOND = '{year: 14'd2025, month: 4'd7, day: 5'd4};

    // Month renumbered so that the year starts in March: (m + 9) mod 12.
    localparam logic [3:0] MARCH_MONTH [16] = '{
        4'd9, 4'd10, 4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
        4'd5, 4'd6,  4'd7,  4'd8, 4'd9, 4'd10, 4'd11, 4'd0
    };

    // Days before the first of each March-based month: (mm * 306 + 5) / 10.
    localparam logic [8:0] MONTH_OFFSET [16] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153, 9'd184, 9'd214,
        9'd245, 9'd275, 9'd306, 9'd337, 9'd0,   9'd0,   9'd0,   9'd0
    };

    // Reciprocal of 100 scaled by 2**21; exact for every dividend below 2**15.
    localparam int         RECIP_SHIFT = 21;
    localparam logic [14:0] RECIP_100  = 15'd20972;

    localparam logic signed [DAYNUM_W-1:0] COUNT_MAX = 25'sd4194303;
    localparam logic signed [DAYNUM_W-1:0] COUNT_MIN = -25'sd4194304;

endpackage

>>> hdl/dtd_cfg.sv
// Target date register file with a plain write port.
// Depends on dtd_pkg for the register codes, date struct and reset values.
module dtd_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dtd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dtd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output dtd_pkg::t_date                     o_first,
    output dtd_pkg::t_date                     o_second
);

    dtd_pkg::t_date r_first;
    dtd_pkg::t_date r_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= dtd_pkg::RST_FIRST;
            r_second <= dtd_pkg::RST_SECOND;
        end else if (i_cfg_we) begin
            unique case (dtd_pkg::t_cfg_idx'(i_cfg_idx))
                dtd_pkg::CFG_FIRST_YEAR: begin
                    r_first.year <= i_cfg_data[dtd_pkg::YEAR_W-1:0];
                end
                dtd_pkg::CFG_FIRST_MONTH: begin
                    r_first.month <= i_cfg_data[dtd_pkg::MONTH_W-1:0];
                end
                dtd_pkg::CFG_FIRST_DAY: begin
                    r_first.day <= i_cfg_data[dtd_pkg::DAY_W-1:0];
                end
                dtd_pkg::CFG_SECOND_YEAR: begin
                    r_second.year <= i_cfg_data[dtd_pkg::YEAR_W-1:0];
                end
                dtd_pkg::CFG_SECOND_MONTH: begin
                    r_second.month <= i_cfg_data[dtd_pkg::MONTH_W-1:0];
                end
                dtd_pkg::CFG_SECOND_DAY: begin
                    r_second.day <= i_cfg_data[dtd_pkg::DAY_W-1:0];
                end
                default: begin
                    // Indexes six and seven address nothing.
                end
            endcase
        end
    end

    assign o_first  = r_first;
    assign o_second = r_second;

endmodule

>>> hdl/dtd_civil.sv
// Civil day number of a date given as adjusted year, March-based month and day.
// Purely combinational; depends on dtd_pkg for widths and constant tables.
module dtd_civil (
    input  logic signed [dtd_pkg::ADJ_W-1:0]    i_adj_year,
    input  logic [3:0]                          i_march_month,
    input  logic [dtd_pkg::DAY_W-1:0]           i_day,
    output logic signed [dtd_pkg::DAYNUM_W-1:0] o_day_num
);

    logic [14:0]                          mag;
    logic [12:0]                          q4;
    logic [29:0]                          prod100;
    logic [7:0]                           q100;
    logic [5:0]                           q400;
    logic signed [dtd_pkg::DAYNUM_W-1:0]  year_days;

    // The only negative adjusted year is -1, whose quotients truncate to zero.
    assign mag       = i_adj_year[dtd_pkg::ADJ_W-1] ? '0 : i_adj_year[14:0];
    assign q4        = 13'(mag >> 2);
    assign prod100   = 30'(mag) * 30'(dtd_pkg::RECIP_100);
    assign q100      = 8'(prod100 >> dtd_pkg::RECIP_SHIFT);
    assign q400      = 6'(q100 >> 2);
    assign year_days = dtd_pkg::DAYNUM_W'(i_adj_year) * 25'sd365;

    assign o_day_num = year_days
                     + $signed(dtd_pkg::DAYNUM_W'(q4))
                     - $signed(dtd_pkg::DAYNUM_W'(q100))
                     + $signed(dtd_pkg::DAYNUM_W'(q400))
                     + $signed(dtd_pkg::DAYNUM_W'(dtd_pkg::MONTH_OFFSET[i_march_month]))
                     + $signed(dtd_pkg::DAYNUM_W'(i_day))
                     - 25'sd1;

endmodule

>>> hdl/days_until_date.sv
// Signed day distance from the current date to one of two configured targets.
// Depends on dtd_pkg, dtd_cfg and dtd_civil.
//
// One date beat is taken every clock cycle unless the input is stalled: a beat
// is captured in the input register, both civil day numbers, their difference
// and the saturation to 23 bits are formed in one pass, and the result is
// registered in the output register and held until the downstream side takes it.
// Upstream is stalled only when both registers are full and the output is
// stalled. A target year of zero repeats the date yearly, rolling to next year
// once the month and day have passed. Targets must be written while idle.
module days_until_date (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dtd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [dtd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [dtd_pkg::YEAR_W-1:0]            i_current_year,
    input  logic [dtd_pkg::MONTH_W-1:0]           i_current_month,
    input  logic [dtd_pkg::DAY_W-1:0]             i_current_day,
    input  logic                                  i_target_select,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [dtd_pkg::COUNT_W-1:0]    o_day_count
);

    dtd_pkg::t_date first_tgt;
    dtd_pkg::t_date second_tgt;
    dtd_pkg::t_date tgt;

    logic                                r_in_vld;
    logic [dtd_pkg::YEAR_W-1:0]          r_cy;
    logic [dtd_pkg::MONTH_W-1:0]         r_cm;
    logic [dtd_pkg::DAY_W-1:0]           r_cd;
    logic                                r_sel;
    logic                                r_out_vld;
    logic signed [dtd_pkg::COUNT_W-1:0]  r_day_count;
    logic signed [dtd_pkg::COUNT_W-1:0]  n_day_count;

    logic                                out_ready;
    logic                                in_ready;
    logic [3:0]                          cur_mm;
    logic [3:0]                          tgt_mm;
    logic                                wrap;
    logic [14:0]                         tgt_year;
    logic signed [dtd_pkg::ADJ_W-1:0]    cur_adj;
    logic signed [dtd_pkg::ADJ_W-1:0]    tgt_adj;
    logic signed [dtd_pkg::DAYNUM_W-1:0] cur_num;
    logic signed [dtd_pkg::DAYNUM_W-1:0] tgt_num;
    logic signed [dtd_pkg::DAYNUM_W-1:0] diff;

    dtd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_first    (first_tgt),
        .o_second   (second_tgt)
    );

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign in_ready   = !r_in_vld || out_ready;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_cy  <= i_current_year;
            r_cm  <= i_current_month;
            r_cd  <= i_current_day;
            r_sel <= i_target_select;
        end
    end

    assign tgt    = r_sel ? second_tgt : first_tgt;
    assign cur_mm = dtd_pkg::MARCH_MONTH[r_cm];
    assign tgt_mm = dtd_pkg::MARCH_MONTH[tgt.month];

    // January and February belong to the previous March-based year.
    assign cur_adj = (cur_mm >= 4'd10) ? $signed({2'b00, r_cy}) - 16'sd1
                                       : $signed({2'b00, r_cy});

    assign wrap = (tgt.month < r_cm) || ((tgt.month == r_cm) && (tgt.day < r_cd));

    always_comb begin
        if (tgt.year != '0) begin
            tgt_year = 15'(tgt.year);
        end else if (wrap) begin
            tgt_year = 15'(r_cy) + 15'd1;
        end else begin
            tgt_year = 15'(r_cy);
        end
    end

    assign tgt_adj = (tgt_mm >= 4'd10) ? $signed({1'b0, tgt_year}) - 16'sd1
                                       : $signed({1'b0, tgt_year});

    dtd_civil u_civil_cur (
        .i_adj_year    (cur_adj),
        .i_march_month (cur_mm),
        .i_day         (r_cd),
        .o_day_num     (cur_num)
    );

    dtd_civil u_civil_tgt (
        .i_adj_year    (tgt_adj),
        .i_march_month (tgt_mm),
        .i_day         (tgt.day),
        .o_day_num     (tgt_num)
    );

    assign diff = tgt_num - cur_num;

    always_comb begin
        if (diff > dtd_pkg::COUNT_MAX) begin
            n_day_count = dtd_pkg::COUNT_MAX[dtd_pkg::COUNT_W-1:0];
        end else if (diff < dtd_pkg::COUNT_MIN) begin
            n_day_count = dtd_pkg::COUNT_MIN[dtd_pkg::COUNT_W-1:0];
        end else begin
            n_day_count = diff[dtd_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_vld) begin
            r_day_count <= n_day_count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_day_count = r_day_count;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_beat_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !(r_out_vld && i_out_stall)) |=> r_out_vld)
        else $error("captured beat did not reach the output register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("pipeline not empty after reset");
`endif

endmodule
